// File: rtl/core/dfs_pkg.sv
// Shared types and constants of the dipole field superposition block.
`default_nettype none
package dfs_pkg;

    // Input item opcodes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] REG_DIR_X  = 3'd0;
    localparam logic [2:0] REG_DIR_Y  = 3'd1;
    localparam logic [2:0] REG_PEAK   = 3'd2;
    localparam logic [2:0] REG_RAMP   = 3'd3;
    localparam logic [2:0] REG_ACTIVE = 3'd4;

    // Restoring divider geometry: numerator is fed MSB first, top aligned.
    localparam int DIV_NW = 84;
    localparam int DIV_DW = 66;
    localparam int DIV_QW = 64;
    localparam int DIV_CW = 7;

    localparam logic [DIV_CW-1:0] STEPS_G     = 7'd84;
    localparam logic [DIV_CW-1:0] STEPS_A     = 7'd58;
    localparam logic [DIV_CW-1:0] STEPS_B     = 7'd64;
    localparam logic [DIV_CW-1:0] STEPS_ALPHA = 7'd64;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ALPHA,
        S_ALPHA_DIV,
        S_ALPHA_WAIT,
        S_READ,
        S_DIFF,
        S_SQ_X,
        S_SQ_Y,
        S_DOT_X,
        S_DOT_Y,
        S_SUM,
        S_G_DIV,
        S_G_WAIT,
        S_A_DIV,
        S_A_WAIT,
        S_B_LO,
        S_B_HI,
        S_B_DIV,
        S_B_WAIT,
        S_F_ACC,
        S_SC_LO,
        S_SC_HI,
        S_SC_FIN,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// File: rtl/core/dfs_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module dfs_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [dfs_pkg::DIV_NW-1:0]    i_num,
    input  wire logic [dfs_pkg::DIV_DW-1:0]    i_den,
    input  wire logic [dfs_pkg::DIV_CW-1:0]    i_steps,
    output logic                               o_done,
    output logic [dfs_pkg::DIV_QW-1:0]         o_quo
);
    logic [dfs_pkg::DIV_NW-1:0] r_num;
    logic [dfs_pkg::DIV_DW-1:0] r_den;
    logic [dfs_pkg::DIV_DW-1:0] r_rem;
    logic [dfs_pkg::DIV_QW-1:0] r_quo;
    logic [dfs_pkg::DIV_CW-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [dfs_pkg::DIV_DW:0]   trial;
    logic [dfs_pkg::DIV_DW:0]   diff;
    logic                       take;

    assign trial = {r_rem, r_num[dfs_pkg::DIV_NW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign take  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[dfs_pkg::DIV_NW-2:0], 1'b0};
            r_rem <= take ? diff[dfs_pkg::DIV_DW-1:0] : trial[dfs_pkg::DIV_DW-1:0];
            r_quo <= {r_quo[dfs_pkg::DIV_QW-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule
`default_nettype wire

// File: rtl/core/dipole_field_superposition.sv
// Top level: 2D dipole table, potential and field summation at a point.
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_stall    opcode, slot, coord_x, coord_y, sim_time
//  output    out        o_out_valid / i_out_stall  potential, field_x, field_y, saturated
//  config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// An evaluate item spends most of its time in the shared restoring divider (one
// quotient bit per cycle, five divisions per dipole).
// Reset sets config defaults and clears control state; datapath and table are not cleared.
// A finished result waits in the output register, and the next item is taken
// meanwhile; a new result waits only if the previous one is still stalled.
`default_nettype none
module dipole_field_superposition #(
    parameter int MAX_DIPOLES = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_opcode,
    input  wire logic [3:0]         i_slot,
    input  wire logic signed [31:0] i_coord_x,
    input  wire logic signed [31:0] i_coord_y,
    input  wire logic [31:0]        i_sim_time,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [47:0]      o_potential,
    output logic signed [47:0]      o_field_x,
    output logic signed [47:0]      o_field_y,
    output logic                    o_saturated
);
    localparam int AW = (MAX_DIPOLES > 1) ? $clog2(MAX_DIPOLES) : 1;
    localparam int CW = $clog2(MAX_DIPOLES + 1);
    localparam logic signed [65:0] ACC_MAX = 66'sd1 <<< 62;
    localparam logic signed [65:0] ACC_MIN = -(66'sd1 <<< 62);

    // Configuration registers.
    logic signed [15:0] r_dir_x, r_dir_y;
    logic [15:0]        r_peak;
    logic [31:0]        r_ramp;
    logic [4:0]         r_active;

    dfs_pkg::t_state r_state, n_state;

    logic [63:0] mem [MAX_DIPOLES];
    logic [63:0] r_rdata;

    logic signed [31:0] r_px, r_py;
    logic [31:0]        r_time;
    logic [47:0]        r_prod;
    logic [31:0]        r_alpha;
    logic [CW-1:0]      r_idx, r_n;
    logic               r_j;
    logic [1:0]         r_sel;
    logic signed [32:0] r_rx, r_ry;
    logic [65:0]        r_sqx, r_sqy, r_s;
    logic signed [48:0] r_dpx, r_dpy;
    logic signed [49:0] r_dot;
    logic [63:0]        r_gm, r_am, r_bm;
    logic [64:0]        r_blo, r_bhi;
    logic signed [63:0] r_acc_p, r_acc_fx, r_acc_fy;
    logic [63:0]        r_plo;
    logic [62:0]        r_phi;
    logic               r_flag;
    logic [47:0]        r_res_p, r_res_fx, r_res_fy;

    logic signed [47:0] r_out_p, r_out_fx, r_out_fy;
    logic               r_out_sat, r_out_valid;

    logic                        in_acc;
    logic                        div_start;
    logic [dfs_pkg::DIV_NW-1:0]  div_num;
    logic [dfs_pkg::DIV_DW-1:0]  div_den;
    logic [dfs_pkg::DIV_CW-1:0]  div_steps;
    logic                        div_done;
    logic [dfs_pkg::DIV_QW-1:0]  div_quo;

    logic [32:0]        rmx, rmy, rm_j;
    logic [15:0]        dm_j;
    logic [49:0]        dotm;
    logic [96:0]        bwide;
    logic signed [63:0] g_term, a_term, b_term, f_term;
    logic signed [63:0] sc_acc;
    logic [63:0]        sc_abs;
    logic [94:0]        sc_prod, sc_shift, sc_limit;
    logic               sc_sat;
    logic [47:0]        sc_m, sc_out;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        mag33 = v[32] ? (~v + 33'd1) : v;
    endfunction

    function automatic logic signed [65:0] acc_sum(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        acc_sum = 66'(a) + 66'(b);
    endfunction

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != dfs_pkg::S_IDLE);

    assign rmx  = mag33(r_rx);
    assign rmy  = mag33(r_ry);
    assign rm_j = r_j ? rmy : rmx;
    assign dm_j = r_j ? (r_dir_y[15] ? 16'(-r_dir_y) : r_dir_y)
                      : (r_dir_x[15] ? 16'(-r_dir_x) : r_dir_x);
    assign dotm = r_dot[49] ? 50'(-r_dot) : r_dot;
    assign bwide = {r_bhi, 32'b0} + {32'b0, r_blo};

    assign g_term = r_dot[49] ? -$signed(div_quo) : $signed(div_quo);
    assign a_term = (r_j ? r_dir_y[15] : r_dir_x[15]) ? -$signed(r_am) : $signed(r_am);
    assign b_term = (r_dot[49] != (r_j ? r_ry[32] : r_rx[32])) ? -$signed(r_bm)
                                                                 : $signed(r_bm);
    assign f_term = b_term - a_term;

    always_comb begin
        case (r_sel)
            2'd0:    sc_acc = r_acc_p;
            2'd1:    sc_acc = r_acc_fx;
            default: sc_acc = r_acc_fy;
        endcase
    end
    assign sc_abs   = sc_acc[63] ? 64'(-sc_acc) : sc_acc;
    assign sc_prod  = {r_phi, 32'b0} + {31'b0, r_plo};
    assign sc_shift = (r_sel == 2'd0) ? (sc_prod >> 24) : (sc_prod >> 16);
    assign sc_limit = sc_acc[63] ? (95'd1 << 47) : ((95'd1 << 47) - 95'd1);
    assign sc_sat   = sc_shift > sc_limit;
    assign sc_m     = sc_sat ? sc_limit[47:0] : sc_shift[47:0];
    assign sc_out   = sc_acc[63] ? (~sc_m + 48'd1) : sc_m;

    dfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dfs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = r_s;
        div_steps = '0;
        case (r_state)
            dfs_pkg::S_IDLE: begin
                if (in_acc && i_opcode == dfs_pkg::OP_EVAL) n_state = dfs_pkg::S_ALPHA;
            end
            dfs_pkg::S_ALPHA: begin
                n_state = (r_time >= r_ramp) ? dfs_pkg::S_READ : dfs_pkg::S_ALPHA_DIV;
            end
            dfs_pkg::S_ALPHA_DIV: begin
                div_start = 1'b1;
                div_num   = {r_prod, 36'b0};
                div_den   = {34'b0, r_ramp};
                div_steps = dfs_pkg::STEPS_ALPHA;
                n_state   = dfs_pkg::S_ALPHA_WAIT;
            end
            dfs_pkg::S_ALPHA_WAIT: begin
                if (div_done) n_state = dfs_pkg::S_READ;
            end
            dfs_pkg::S_READ: begin
                n_state = (r_idx == r_n) ? dfs_pkg::S_SC_LO : dfs_pkg::S_DIFF;
            end
            dfs_pkg::S_DIFF: n_state = dfs_pkg::S_SQ_X;
            dfs_pkg::S_SQ_X: begin
                // A dipole sitting exactly on the point contributes nothing.
                n_state = (r_rx == 0 && r_ry == 0) ? dfs_pkg::S_READ : dfs_pkg::S_SQ_Y;
            end
            dfs_pkg::S_SQ_Y:  n_state = dfs_pkg::S_DOT_X;
            dfs_pkg::S_DOT_X: n_state = dfs_pkg::S_DOT_Y;
            dfs_pkg::S_DOT_Y: n_state = dfs_pkg::S_SUM;
            dfs_pkg::S_SUM:   n_state = dfs_pkg::S_G_DIV;
            dfs_pkg::S_G_DIV: begin
                div_start = 1'b1;
                div_num   = {dotm, 34'b0};
                div_steps = dfs_pkg::STEPS_G;
                n_state   = dfs_pkg::S_G_WAIT;
            end
            dfs_pkg::S_G_WAIT: begin
                if (div_done) n_state = dfs_pkg::S_A_DIV;
            end
            dfs_pkg::S_A_DIV: begin
                div_start = 1'b1;
                div_num   = {dm_j, 68'b0};
                div_steps = dfs_pkg::STEPS_A;
                n_state   = dfs_pkg::S_A_WAIT;
            end
            dfs_pkg::S_A_WAIT: begin
                if (div_done) n_state = dfs_pkg::S_B_LO;
            end
            dfs_pkg::S_B_LO: n_state = dfs_pkg::S_B_HI;
            dfs_pkg::S_B_HI: n_state = dfs_pkg::S_B_DIV;
            dfs_pkg::S_B_DIV: begin
                div_start = 1'b1;
                div_num   = {bwide[54:0], 9'b0, 20'b0};
                div_steps = dfs_pkg::STEPS_B;
                n_state   = dfs_pkg::S_B_WAIT;
            end
            dfs_pkg::S_B_WAIT: begin
                if (div_done) n_state = dfs_pkg::S_F_ACC;
            end
            dfs_pkg::S_F_ACC: begin
                n_state = r_j ? dfs_pkg::S_READ : dfs_pkg::S_A_DIV;
            end
            dfs_pkg::S_SC_LO: n_state = dfs_pkg::S_SC_HI;
            dfs_pkg::S_SC_HI: n_state = dfs_pkg::S_SC_FIN;
            dfs_pkg::S_SC_FIN: begin
                n_state = (r_sel == 2'd2) ? dfs_pkg::S_DONE : dfs_pkg::S_SC_LO;
            end
            dfs_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) n_state = dfs_pkg::S_IDLE;
            end
            default: n_state = dfs_pkg::S_IDLE;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_x  <= 16'sd0;
            r_dir_y  <= 16'sd16384;
            r_peak   <= 16'd0;
            r_ramp   <= 32'd65536;
            r_active <= 5'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dfs_pkg::REG_DIR_X:  r_dir_x  <= i_cfg_data[15:0];
                dfs_pkg::REG_DIR_Y:  r_dir_y  <= i_cfg_data[15:0];
                dfs_pkg::REG_PEAK:   r_peak   <= i_cfg_data[15:0];
                dfs_pkg::REG_RAMP:   r_ramp   <= i_cfg_data;
                dfs_pkg::REG_ACTIVE: r_active <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Dipole table: x in the low half, y in the high half.
    always_ff @(posedge i_clk) begin
        if (in_acc && i_opcode == dfs_pkg::OP_WRITE && int'(i_slot) < MAX_DIPOLES) begin
            mem[AW'(i_slot)] <= {i_coord_y, i_coord_x};
        end
        if (r_state == dfs_pkg::S_READ && r_idx != r_n) begin
            r_rdata <= mem[r_idx[AW-1:0]];
        end
    end

    // Loop control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_j   <= 1'b0;
            r_sel <= 2'd0;
        end else begin
            case (r_state)
                dfs_pkg::S_IDLE: begin
                    r_idx <= '0;
                    r_j   <= 1'b0;
                    r_sel <= 2'd0;
                end
                dfs_pkg::S_SQ_X: begin
                    if (r_rx == 0 && r_ry == 0) r_idx <= r_idx + 1'b1;
                end
                dfs_pkg::S_F_ACC: begin
                    r_j <= ~r_j;
                    if (r_j) r_idx <= r_idx + 1'b1;
                end
                dfs_pkg::S_SC_FIN: r_sel <= r_sel + 2'd1;
                default: ;
            endcase
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            dfs_pkg::S_IDLE: begin
                if (in_acc) begin
                    r_px     <= i_coord_x;
                    r_py     <= i_coord_y;
                    r_time   <= i_sim_time;
                    r_n      <= (int'(r_active) > MAX_DIPOLES) ? CW'(MAX_DIPOLES)
                                                               : CW'(r_active);
                    r_acc_p  <= '0;
                    r_acc_fx <= '0;
                    r_acc_fy <= '0;
                    r_flag   <= 1'b0;
                end
            end
            dfs_pkg::S_ALPHA: begin
                r_prod  <= r_peak * r_time;
                r_alpha <= {r_peak, 16'b0};
            end
            dfs_pkg::S_ALPHA_WAIT: begin
                if (div_done) r_alpha <= div_quo[31:0];
            end
            dfs_pkg::S_DIFF: begin
                r_rx <= {r_rdata[31], r_rdata[31:0]} - {r_px[31], r_px};
                r_ry <= {r_rdata[63], r_rdata[63:32]} - {r_py[31], r_py};
            end
            dfs_pkg::S_SQ_X:  r_sqx <= rmx * rmx;
            dfs_pkg::S_SQ_Y:  r_sqy <= rmy * rmy;
            dfs_pkg::S_DOT_X: r_dpx <= 49'(r_dir_x * r_rx);
            dfs_pkg::S_DOT_Y: r_dpy <= 49'(r_dir_y * r_ry);
            dfs_pkg::S_SUM: begin
                r_s   <= r_sqx + r_sqy;
                r_dot <= 50'(r_dpx) + 50'(r_dpy);
            end
            dfs_pkg::S_G_WAIT: begin
                if (div_done) begin
                    r_gm <= div_quo;
                    if (acc_sum(r_acc_p, g_term) > ACC_MAX) begin
                        r_acc_p <= 64'(ACC_MAX);
                        r_flag  <= 1'b1;
                    end else if (acc_sum(r_acc_p, g_term) < ACC_MIN) begin
                        r_acc_p <= 64'(ACC_MIN);
                        r_flag  <= 1'b1;
                    end else begin
                        r_acc_p <= 64'(acc_sum(r_acc_p, g_term));
                    end
                end
            end
            dfs_pkg::S_A_WAIT: begin
                if (div_done) r_am <= div_quo;
            end
            dfs_pkg::S_B_LO: r_blo <= r_gm[31:0] * rm_j;
            dfs_pkg::S_B_HI: r_bhi <= r_gm[63:32] * rm_j;
            dfs_pkg::S_B_WAIT: begin
                if (div_done) r_bm <= div_quo;
            end
            dfs_pkg::S_F_ACC: begin
                if (r_j) begin
                    if (acc_sum(r_acc_fy, f_term) > ACC_MAX) begin
                        r_acc_fy <= 64'(ACC_MAX);
                        r_flag   <= 1'b1;
                    end else if (acc_sum(r_acc_fy, f_term) < ACC_MIN) begin
                        r_acc_fy <= 64'(ACC_MIN);
                        r_flag   <= 1'b1;
                    end else begin
                        r_acc_fy <= 64'(acc_sum(r_acc_fy, f_term));
                    end
                end else begin
                    if (acc_sum(r_acc_fx, f_term) > ACC_MAX) begin
                        r_acc_fx <= 64'(ACC_MAX);
                        r_flag   <= 1'b1;
                    end else if (acc_sum(r_acc_fx, f_term) < ACC_MIN) begin
                        r_acc_fx <= 64'(ACC_MIN);
                        r_flag   <= 1'b1;
                    end else begin
                        r_acc_fx <= 64'(acc_sum(r_acc_fx, f_term));
                    end
                end
            end
            dfs_pkg::S_SC_LO: r_plo <= r_alpha * sc_abs[31:0];
            dfs_pkg::S_SC_HI: r_phi <= r_alpha * sc_abs[62:32];
            dfs_pkg::S_SC_FIN: begin
                if (sc_sat) r_flag <= 1'b1;
                case (r_sel)
                    2'd0:    r_res_p  <= sc_out;
                    2'd1:    r_res_fx <= sc_out;
                    default: r_res_fy <= sc_out;
                endcase
            end
            default: ;
        endcase
    end

    assign o_potential = r_out_p;
    assign o_field_x   = r_out_fx;
    assign o_field_y   = r_out_fy;
    assign o_saturated = r_out_sat;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == dfs_pkg::S_DONE && (!r_out_valid || !i_out_stall)) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == dfs_pkg::S_DONE && (!r_out_valid || !i_out_stall)) begin
            r_out_p   <= r_res_p;
            r_out_fx  <= r_res_fx;
            r_out_fy  <= r_res_fy;
            r_out_sat <= r_flag;
        end
    end
endmodule
`default_nettype wire
